>>> design/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and codes for the dirty rectangle tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int unsigned CoordW = 16;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_WHOLE = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_REGION  = 2'd1,
    KIND_WHOLE   = 2'd2,
    KIND_NOTHING = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_COVERED   = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_OFFSCREEN = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } box_t;

  // token that walks the cell chain during an add scan
  typedef struct packed {
    logic active;   // token is still looking (no cover/replace yet)
    logic replaced; // replacement already done, zero the width of covered entries
    box_t rect;
  } tok_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CoordW-1:0] rect_x;
    logic [CoordW-1:0] rect_y;
    logic [CoordW-1:0] rect_w;
    logic [CoordW-1:0] rect_h;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        status;
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [CoordW-1:0] out_w;
    logic [CoordW-1:0] out_h;
    logic              last;
  } out_t;

  // a covers b, compared on 17 bits so sums never wrap
  function automatic logic covers(box_t a, box_t b);
    logic [CoordW:0] ae_x, ae_y, be_x, be_y;
    ae_x = {1'b0, a.x} + {1'b0, a.w};
    ae_y = {1'b0, a.y} + {1'b0, a.h};
    be_x = {1'b0, b.x} + {1'b0, b.w};
    be_y = {1'b0, b.y} + {1'b0, b.h};
    return (a.x <= b.x) && (a.y <= b.y) && (ae_x >= be_x) && (ae_y >= be_y);
  endfunction

endpackage

>>> design/drt_if.sv
// ----------------------------------------------------------------------------
// drt_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface drt_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/drt_cell.sv
// ----------------------------------------------------------------------------
// drt_cell
// One table slot: checks the passing token against its entry, shifts, fills or clears.
// ----------------------------------------------------------------------------
module drt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          scan_i,      // token step this cycle
  input  logic          shift_i,     // flush shift toward cell 0
  input  logic          clear_i,
  input  logic          fill_i,      // append lands here
  input  drt_pkg::box_t fill_box_i,
  input  drt_pkg::tok_t tok_i,
  input  logic          nb_valid_i,  // neighbor entry for shift
  input  drt_pkg::box_t nb_box_i,
  output drt_pkg::tok_t tok_o,
  output logic          valid_o,
  output drt_pkg::box_t box_o
);
  import drt_pkg::*;

  logic valid_q, valid_d;
  box_t box_q, box_d;
  tok_t tok_q, tok_d;

  always_comb begin
    valid_d = valid_q;
    box_d   = box_q;
    tok_d   = tok_i;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = nb_valid_i;
      box_d   = nb_box_i;
    end else if (fill_i) begin
      valid_d = 1'b1;
      box_d   = fill_box_i;
    end else if (scan_i && valid_q) begin
      if (tok_i.replaced) begin
        if (covers(tok_i.rect, box_q)) box_d.w = '0;
      end else if (tok_i.active) begin
        if (covers(box_q, tok_i.rect)) begin
          tok_d.active = 1'b0;
        end else if (covers(tok_i.rect, box_q)) begin
          box_d = tok_i.rect;
          tok_d.active   = 1'b0;
          tok_d.replaced = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (scan_i) tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;
  assign box_o   = box_q;
endmodule

>>> design/dirty_rect_tracker_unit.sv
// add: token walks one cell per cycle down the whole chain (S_SCAN), then commits in S_DONE;
// the status beat is registered in S_DONE and the unit returns to idle through S_OUT
// ignored or offscreen add, whole-screen or nothing flush: one beat, then idle via S_OUT
// flush of n entries: one beat per cycle while the sink is ready, shifted out of cell 0
// one item at a time; for an add, the walk of the token down the chain sets the rate
// reset clears count, valid bits, whole-screen flag, screen to 640x480; entries no clear
// ----------------------------------------------------------------------------
// dirty_rect_tracker_unit
// Bounded dirty rectangle table built as a chain of slot cells.
// ----------------------------------------------------------------------------
module dirty_rect_tracker_unit #(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  drt_if.sink                        in_if,
  drt_if.source                      out_if,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [drt_pkg::CoordW-1:0] cfg_data_i
);
  import drt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned PosW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DONE  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CoordW-1:0] sw_q, sh_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              whole_q, whole_d;
  out_t              res_q, res_d;
  logic              ov_q, ov_d;
  box_t              rect_q, rect_d;

  tok_t tok_in  [MAX_REGIONS];
  tok_t tok_out [MAX_REGIONS];
  logic cv      [MAX_REGIONS];
  box_t cb      [MAX_REGIONS];
  logic         scan, shift, clr;

  // clip
  logic signed [CoordW+1:0] cx, cy, cw, ch;
  logic [CoordW-1:0]        cxw, cyh, cww, chh;
  logic                     offs;
  in_t                      inb;

  assign inb = in_if.data;

  always_comb begin
    cx = {{2{inb.rect_x[CoordW-1]}}, inb.rect_x};
    cy = {{2{inb.rect_y[CoordW-1]}}, inb.rect_y};
    cw = {2'b00, inb.rect_w};
    ch = {2'b00, inb.rect_h};
    if (cx < 0) begin
      cw = cw + cx;
      cx = '0;
    end
    if (cy < 0) begin
      ch = ch + cy;
      cy = '0;
    end
    offs = (cx >= $signed({2'b00, sw_q})) || (cy >= $signed({2'b00, sh_q}));
    if (cx + cw > $signed({2'b00, sw_q})) cw = $signed({2'b00, sw_q}) - cx;
    if (cy + ch > $signed({2'b00, sh_q})) ch = $signed({2'b00, sh_q}) - cy;
    if (cw <= 0 || ch <= 0) offs = 1'b1;
    cxw = cx[CoordW-1:0];
    cyh = cy[CoordW-1:0];
    cww = cw[CoordW-1:0];
    chh = ch[CoordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= CoordW'(640);
      sh_q <= CoordW'(480);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) sw_q <= cfg_data_i;
      else sh_q <= cfg_data_i;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign tok_in[g] = (pos_q == '0) ? tok_t'{1'b1, 1'b0, rect_q} : '0;
      end else begin : g_rest
        assign tok_in[g] = tok_out[g-1];
      end
      drt_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .scan_i     (scan),
        .shift_i    (shift),
        .clear_i    (clr),
        .fill_i     (state_q == S_DONE && ov_q && cnt_q == CntW'(g)),
        .fill_box_i (rect_q),
        .tok_i      (tok_in[g]),
        .nb_valid_i ((g == MAX_REGIONS - 1) ? 1'b0 : cv[(g + 1) % MAX_REGIONS]),
        .nb_box_i   (cb[(g + 1) % MAX_REGIONS]),
        .tok_o      (tok_out[g]),
        .valid_o    (cv[g]),
        .box_o      (cb[g])
      );
    end
  endgenerate

  // token exits the chain with active still set: nobody covered or was replaced
  tok_t tail;
  assign tail = tok_out[MAX_REGIONS-1];

  assign in_if.ready = (state_q == S_IDLE) && !(out_if.valid && !out_if.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    whole_d = whole_q;
    res_d   = res_q;
    ov_d    = ov_q;
    rect_d  = rect_q;
    scan    = 1'b0;
    shift   = 1'b0;
    clr     = 1'b0;
    if (out_if.valid && out_if.ready) res_d = '0;
    case (state_q)
      S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          case (inb.mode)
            MODE_ADD: begin
              res_d = '0;
              res_d.kind = KIND_STATUS;
              res_d.last = 1'b1;
              if (whole_q) begin
                res_d.status = ST_IGNORED;
                state_d = S_OUT;
              end else if (offs) begin
                res_d.status = ST_OFFSCREEN;
                state_d = S_OUT;
              end else begin
                rect_d  = '{x: cxw, y: cyh, w: cww, h: chh};
                pos_d   = '0;
                state_d = S_SCAN;
              end
            end
            MODE_WHOLE: whole_d = 1'b1;
            MODE_FLUSH: begin
              res_d = '0;
              res_d.last = 1'b1;
              if (whole_q) begin
                res_d.kind = KIND_WHOLE;
                clr = 1'b1;
                cnt_d = '0;
                whole_d = 1'b0;
                state_d = S_OUT;
              end else if (cnt_q == '0) begin
                res_d.kind = KIND_NOTHING;
                state_d = S_OUT;
              end else begin
                state_d = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        scan  = 1'b1;
        pos_d = pos_q + PosW'(1);
        if (pos_q == PosW'(MAX_REGIONS)) begin
          state_d = S_DONE;
          ov_d = tail.active && (cnt_q < CntW'(MAX_REGIONS));
          res_d.status = !tail.active ? (tail.replaced ? ST_REPLACED : ST_COVERED)
                       : (cnt_q < CntW'(MAX_REGIONS)) ? ST_APPENDED : ST_OVERFLOW;
          if (tail.active && cnt_q >= CntW'(MAX_REGIONS)) whole_d = 1'b1;
        end
      end
      S_DONE: begin
        if (ov_q) cnt_d = cnt_q + CntW'(1);
        ov_d = 1'b0;
        state_d = S_OUT;
      end
      S_FLUSH: begin
        if (!out_if.valid || out_if.ready) begin
          res_d = '0;
          res_d.kind  = KIND_REGION;
          res_d.out_x = cb[0].x;
          res_d.out_y = cb[0].y;
          res_d.out_w = cb[0].w;
          res_d.out_h = cb[0].h;
          res_d.last  = (cnt_q == CntW'(1));
          shift = 1'b1;
          cnt_d = cnt_q - CntW'(1);
          state_d = S_OUT;
          if (cnt_q != CntW'(1)) state_d = S_FLUSH;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  logic ovalid_q, ovalid_d;
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_if.valid && out_if.ready) ovalid_d = 1'b0;
    if ((state_q == S_IDLE && in_if.valid && in_if.ready &&
         (inb.mode == MODE_FLUSH || inb.mode == MODE_ADD) && state_d == S_OUT) ||
        (state_q == S_DONE) || shift) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pos_q    <= '0;
      whole_q  <= 1'b0;
      ov_q     <= 1'b0;
      ovalid_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      whole_q  <= whole_d;
      ov_q     <= ov_d;
      ovalid_q <= ovalid_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_REGIONS)) else $error("count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result lost");
  a_nostart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_if.ready) else $error("accept while busy");
endmodule
